FILE: rtl/wav_header_parser_core_assert.svh
// Assertion macros shared by the WAV header parser RTL.
// Expects a clock named clk and an active-low reset named rst_n in the including module.
`ifndef WAV_HEADER_PARSER_CORE_ASSERT_SVH
`define WAV_HEADER_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define WHP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wav header parser: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define WHP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wav header parser: next-cycle check failed");

`endif

FILE: rtl/whp_pkg.sv
// Shared types, constants and helpers for the WAV header parser.
// No dependencies; used by whp_fmt_check and wav_header_parser_core.
package whp_pkg;

  localparam int BYTE_W      = 8;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int OUT_TDATA_W = 128;
  localparam int IDX_W       = 5;
  localparam int SKIP_W      = 33;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_PARSE   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PAYLOAD = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADRIFF = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADWAVE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TRUNC   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BADFMT  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_END     = 3'd6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHANNELS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE     = 8'd1;

  localparam logic [15:0] MAX_CHANNELS_RST = 16'd16;
  localparam logic [31:0] MAX_RATE_RST     = 32'd192000;

  // Chunk tags as they appear when the four bytes are shifted in from the right.
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [15:0] FMT_TAG_PCM = 16'd1;

  localparam logic [1:0] SFC_S16 = 2'd0;
  localparam logic [1:0] SFC_P24 = 2'd1;
  localparam logic [1:0] SFC_S32 = 2'd2;

  typedef struct packed {
    logic [15:0] fmt_tag;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [31:0] data_len;
    logic [15:0] max_channels;
    logic [31:0] max_rate;
  } fmt_fields_t;

  function automatic logic [1:0] sample_format_code(input logic [15:0] bits);
    logic [1:0] code;
    code = SFC_S16;
    if (bits == 16'd24) begin
      code = SFC_P24;
    end else if (bits == 16'd32) begin
      code = SFC_S32;
    end
    return code;
  endfunction

endpackage

FILE: rtl/whp_fmt_check.sv
// Format validation for the WAV header parser: PCM tag, channel and rate ranges,
// supported sample widths and a nonzero data size. Depends on whp_pkg.
module whp_fmt_check (
  input  whp_pkg::fmt_fields_t fields,
  output logic                 fmt_ok
);
  import whp_pkg::*;

  logic bits_ok;
  logic chan_ok;
  logic rate_ok;

  assign bits_ok = (fields.bits == 16'd8) || (fields.bits == 16'd16) ||
                   (fields.bits == 16'd24) || (fields.bits == 16'd32);
  assign chan_ok = (fields.channels != 16'd0) && (fields.channels <= fields.max_channels);
  assign rate_ok = (fields.rate != 32'd0) && (fields.rate <= fields.max_rate);

  assign fmt_ok = (fields.fmt_tag == FMT_TAG_PCM) && chan_ok && rate_ok && bits_ok &&
                  (fields.data_len != 32'd0);

endmodule

FILE: rtl/wav_header_parser_core.sv
// Top level of the WAV header parser: byte-wide RIFF/WAVE header walk and payload pass-through.
// Depends on whp_pkg, whp_fmt_check and wav_header_parser_core_assert.svh.

// The block takes a WAV file one byte per input beat (in_tlast marks end of file and carries
// no byte) and returns exactly one result beat per input beat in the next cycle, at a sustained
// rate of one byte per clock while out_tready is held high; the only storage in the path is the
// parser state and the single output register, and a new byte is taken whenever that register
// is empty or being drained. Each result carries a status in out_tuser and, in out_tdata, the
// payload byte plus the format fields gathered so far. Errors and end of audio are sticky until
// reset. The format limits on the cfg_ port may only be written while no beat is in flight.
module wav_header_parser_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [whp_pkg::BYTE_W-1:0]           in_tdata,    // [7:0] byte_value
  input  logic                                 in_tlast,    // stream_end
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [7:0] payload_byte, [8] header_ok, [24:9] format_tag, [40:25] channels,
  // [72:41] sample_rate_hz, [88:73] sample_bits, [120:89] data_bytes,
  // [122:121] sample_format_code, [127:123] zero
  output logic [whp_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic [whp_pkg::STATUS_W-1:0]         out_tuser,   // [2:0] status
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [whp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [whp_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import whp_pkg::*;

  `include "wav_header_parser_core_assert.svh"

  typedef enum logic [3:0] {
    PH_RIFF,
    PH_RSIZE,
    PH_WAVE,
    PH_HDR_FMT,
    PH_SKIP_FMT,
    PH_FMT_BODY,
    PH_HDR_DATA,
    PH_SKIP_DATA,
    PH_PAYLOAD
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt, idx_inc;
  logic [31:0]         tag_r, tag_nxt;
  logic [31:0]         size_r, size_nxt;
  logic [SKIP_W-1:0]   skip_r, skip_nxt;
  logic [15:0]         fmt_tag_r, fmt_tag_nxt;
  logic [15:0]         chan_r, chan_nxt;
  logic [31:0]         rate_r, rate_nxt;
  logic [15:0]         bits_r, bits_nxt;
  logic [31:0]         dsize_r, dsize_nxt;
  logic [STATUS_W-1:0] sticky_r, sticky_nxt;
  logic                hvalid_r, hvalid_nxt;
  logic [15:0]         max_chan_r;
  logic [31:0]         max_rate_r;

  logic                    out_tvalid_r;
  logic [OUT_TDATA_W-1:0]  out_tdata_r, tdata_nxt;
  logic [STATUS_W-1:0]     out_tuser_r, status_nxt;
  logic [BYTE_W-1:0]       pay_nxt;

  logic                in_fire;
  logic [BYTE_W-1:0]   b;
  logic [31:0]         tag_shifted;
  logic [31:0]         size_shifted;
  logic [SKIP_W-1:0]   padded_size;
  logic [SKIP_W-1:0]   fmt_excess;
  fmt_fields_t         chk_fields;
  logic                fmt_ok;

  assign in_tready  = !out_tvalid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign b            = in_tdata;
  assign idx_inc      = idx_r + 5'd1;
  assign tag_shifted  = {tag_r[23:0], b};
  assign size_shifted = {b, size_r[31:8]};
  // Chunk sizes are rounded up to even; the sum needs the 33rd bit.
  assign padded_size  = {1'b0, size_shifted} + {32'd0, size_shifted[0]};
  assign fmt_excess   = (size_r > 32'd16) ?
                        ({1'b0, size_r} - 33'd16 + {32'd0, size_r[0]}) : 33'd0;

  // Checked on the last byte of a data chunk header, so the size is the shifted one.
  always_comb begin
    chk_fields.fmt_tag      = fmt_tag_r;
    chk_fields.channels     = chan_r;
    chk_fields.rate         = rate_r;
    chk_fields.bits         = bits_r;
    chk_fields.data_len     = size_shifted;
    chk_fields.max_channels = max_chan_r;
    chk_fields.max_rate     = max_rate_r;
  end

  whp_fmt_check u_fmt_check (
    .fields (chk_fields),
    .fmt_ok (fmt_ok)
  );

  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    tag_nxt     = tag_r;
    size_nxt    = size_r;
    skip_nxt    = skip_r;
    fmt_tag_nxt = fmt_tag_r;
    chan_nxt    = chan_r;
    rate_nxt    = rate_r;
    bits_nxt    = bits_r;
    dsize_nxt   = dsize_r;
    sticky_nxt  = sticky_r;
    hvalid_nxt  = hvalid_r;
    status_nxt  = ST_PARSE;
    pay_nxt     = '0;

    if (sticky_r != ST_PARSE) begin
      status_nxt = sticky_r;
    end else if (in_tlast) begin
      sticky_nxt = (phase_r == PH_PAYLOAD) ? ST_END : ST_TRUNC;
    end else begin
      unique case (phase_r)
        PH_RIFF, PH_WAVE: begin
          tag_nxt = tag_shifted;
          idx_nxt = idx_inc;
          if (idx_inc >= 5'd4) begin
            idx_nxt = '0;
            if (phase_r == PH_RIFF) begin
              if (tag_shifted != TAG_RIFF) sticky_nxt = ST_BADRIFF;
              else phase_nxt = PH_RSIZE;
            end else begin
              if (tag_shifted != TAG_WAVE) sticky_nxt = ST_BADWAVE;
              else phase_nxt = PH_HDR_FMT;
            end
          end
        end
        PH_RSIZE: begin
          size_nxt = size_shifted;
          idx_nxt  = idx_inc;
          if (idx_inc >= 5'd4) begin
            idx_nxt   = '0;
            phase_nxt = PH_WAVE;
          end
        end
        PH_HDR_FMT, PH_HDR_DATA: begin
          // First four bytes build the chunk id, the next four its size.
          if (idx_r < 5'd4) tag_nxt = tag_shifted;
          else size_nxt = size_shifted;
          idx_nxt = idx_inc;
          if (idx_inc >= 5'd8) begin
            idx_nxt = '0;
            if (phase_r == PH_HDR_FMT) begin
              if (tag_r == TAG_FMT) begin
                phase_nxt = PH_FMT_BODY;
              end else begin
                skip_nxt  = padded_size;
                phase_nxt = (padded_size != '0) ? PH_SKIP_FMT : PH_HDR_FMT;
              end
            end else begin
              if (tag_r == TAG_DATA) begin
                dsize_nxt = size_shifted;
                if (fmt_ok) begin
                  hvalid_nxt = 1'b1;
                  phase_nxt  = PH_PAYLOAD;
                end else begin
                  sticky_nxt = ST_BADFMT;
                end
              end else begin
                skip_nxt  = padded_size;
                phase_nxt = (padded_size != '0) ? PH_SKIP_DATA : PH_HDR_DATA;
              end
            end
          end
        end
        PH_SKIP_FMT, PH_SKIP_DATA: begin
          if (skip_r != '0) skip_nxt = skip_r - 33'd1;
          if (skip_nxt == '0) begin
            idx_nxt   = '0;
            phase_nxt = (phase_r == PH_SKIP_FMT) ? PH_HDR_FMT : PH_HDR_DATA;
          end
        end
        PH_FMT_BODY: begin
          unique case (idx_r[3:0])
            4'd0:    fmt_tag_nxt[7:0]  = b;
            4'd1:    fmt_tag_nxt[15:8] = b;
            4'd2:    chan_nxt[7:0]     = b;
            4'd3:    chan_nxt[15:8]    = b;
            4'd4:    rate_nxt[7:0]     = b;
            4'd5:    rate_nxt[15:8]    = b;
            4'd6:    rate_nxt[23:16]   = b;
            4'd7:    rate_nxt[31:24]   = b;
            4'd14:   bits_nxt[7:0]     = b;
            4'd15:   bits_nxt[15:8]    = b;
            default: ;
          endcase
          idx_nxt = idx_inc;
          if (idx_inc >= 5'd16) begin
            idx_nxt   = '0;
            skip_nxt  = fmt_excess;
            phase_nxt = (fmt_excess != '0) ? PH_SKIP_DATA : PH_HDR_DATA;
          end
        end
        PH_PAYLOAD: begin
          status_nxt = ST_PAYLOAD;
          pay_nxt    = b;
        end
        default: begin
          phase_nxt = PH_RIFF;
          idx_nxt   = '0;
        end
      endcase
    end

    if (sticky_nxt != ST_PARSE) status_nxt = sticky_nxt;
  end

  assign tdata_nxt = {5'd0, sample_format_code(bits_nxt), dsize_nxt, bits_nxt, rate_nxt,
                      chan_nxt, fmt_tag_nxt, hvalid_nxt, pay_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_RIFF;
      idx_r        <= '0;
      tag_r        <= '0;
      size_r       <= '0;
      skip_r       <= '0;
      fmt_tag_r    <= '0;
      chan_r       <= '0;
      rate_r       <= '0;
      bits_r       <= '0;
      dsize_r      <= '0;
      sticky_r     <= ST_PARSE;
      hvalid_r     <= 1'b0;
      max_chan_r   <= MAX_CHANNELS_RST;
      max_rate_r   <= MAX_RATE_RST;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MAX_CHANNELS) max_chan_r <= cfg_data[15:0];
        else if (cfg_index == CFG_MAX_RATE) max_rate_r <= cfg_data;
      end
      if (in_fire) begin
        phase_r   <= phase_nxt;
        idx_r     <= idx_nxt;
        tag_r     <= tag_nxt;
        size_r    <= size_nxt;
        skip_r    <= skip_nxt;
        fmt_tag_r <= fmt_tag_nxt;
        chan_r    <= chan_nxt;
        rate_r    <= rate_nxt;
        bits_r    <= bits_nxt;
        dsize_r   <= dsize_nxt;
        sticky_r  <= sticky_nxt;
        hvalid_r  <= hvalid_nxt;
      end
      if (in_fire) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_tvalid.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_tdata_r <= tdata_nxt;
      out_tuser_r <= status_nxt;
    end
  end

  `WHP_ASSERT_NOW(a_valid_header_in_payload, hvalid_r, phase_r == PH_PAYLOAD)
  `WHP_ASSERT_NOW(a_skip_nonzero, (phase_r == PH_SKIP_FMT) || (phase_r == PH_SKIP_DATA),
                  skip_r != '0)
  `WHP_ASSERT_NEXT(a_sticky_holds, sticky_r != ST_PARSE, sticky_r == $past(sticky_r))
  `WHP_ASSERT_NOW(a_index_bound, phase_r != PH_FMT_BODY, idx_r < 5'd8)
  `WHP_ASSERT_NEXT(a_payload_marked,
                   in_fire && !in_tlast && (phase_r == PH_PAYLOAD) && (sticky_r == ST_PARSE),
                   (out_tuser_r == ST_PAYLOAD) && out_tdata_r[8])

endmodule
